FILE: rtl/core/printable_string_extractor_macros.svh
`ifndef PRINTABLE_STRING_EXTRACTOR_MACROS_SVH
`define PRINTABLE_STRING_EXTRACTOR_MACROS_SVH

// same-cycle implication, ignored while in reset
`define PSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pse assertion failed");

// next-cycle implication, ignored while in reset
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pse assertion failed");

`endif

FILE: rtl/core/pse_pkg.sv
`default_nettype none

package pse_pkg;

  localparam int RUN_DEPTH_DEF = 64;

  localparam int DATA_W = 8;
  localparam int CHAR_W = 7;
  localparam int OFF_W  = 32;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] MIN_LEN_RST = 7'd4;

  localparam logic [DATA_W-1:0] CODE_NUL   = 8'h00;
  localparam logic [DATA_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [DATA_W-1:0] PRINT_HI   = 8'h7E;

  // one replay read issued toward the output pipeline
  typedef struct packed {
    logic             issue;
    logic             last;
    logic [OFF_W-1:0] offset;
  } pse_rd_tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/pse_if.sv
`default_nettype none

interface pse_in_if;
  logic                        valid;
  logic                        ready;
  logic [pse_pkg::DATA_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pse_out_if;
  logic                        valid;
  logic                        ready;
  logic [pse_pkg::CHAR_W-1:0]  text_char;
  logic [pse_pkg::OFF_W-1:0]   run_offset;
  logic                        run_last;

  modport source (output valid, output text_char, output run_offset, output run_last,
                  input ready);
  modport sink   (input valid, input text_char, input run_offset, input run_last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pse_run_mem.sv
`default_nettype none

module pse_run_mem #(
  parameter int RUN_DEPTH = pse_pkg::RUN_DEPTH_DEF,
  parameter int ADDR_W    = $clog2(RUN_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [pse_pkg::DATA_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [pse_pkg::DATA_W-1:0] rd_data
);

  logic [pse_pkg::DATA_W-1:0] mem [RUN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pse_scan.sv
`default_nettype none

module pse_scan #(
  parameter int RUN_DEPTH = pse_pkg::RUN_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pse_in_if.sink                           in_ch,
  input  wire logic                        cfg_we,
  input  wire logic [pse_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        rd_ok,
  output pse_pkg::pse_rd_tag_t             rd_tag,
  output logic                             wr_en,
  output logic [$clog2(RUN_DEPTH)-1:0]     wr_addr,
  output logic [pse_pkg::DATA_W-1:0]       wr_data,
  output logic [$clog2(RUN_DEPTH)-1:0]     rd_addr
);

  localparam int ADDR_W = $clog2(RUN_DEPTH);
  localparam int CNT_W  = $clog2(RUN_DEPTH + 1);
  localparam int CFG_W  = pse_pkg::CFG_W;
  localparam int OFF_W  = pse_pkg::OFF_W;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_REPLAY  = 1'b1;

  logic                 st_r,      st_nxt;
  logic [CNT_W-1:0]     cnt_r,     cnt_nxt;
  logic [CNT_W-1:0]     rep_len_r, rep_len_nxt;
  logic [ADDR_W-1:0]    rd_idx_r,  rd_idx_nxt;
  logic [OFF_W-1:0]     start_r,   start_nxt;
  logic [OFF_W-1:0]     pos_r,     pos_nxt;
  logic [CFG_W-1:0]     min_len_r;

  logic                 accept;
  logic                 printable;
  logic                 term;
  logic [CFG_W-1:0]     need;
  logic                 rd_last;
  logic                 issue;

  assign in_ch.ready = (st_r == ST_COLLECT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign printable   = (in_ch.data_byte >= pse_pkg::PRINT_LO) &&
                       (in_ch.data_byte <= pse_pkg::PRINT_HI);
  assign term        = (in_ch.data_byte == pse_pkg::CODE_NUL) ||
                       (in_ch.data_byte == pse_pkg::CODE_CR)  ||
                       (in_ch.data_byte == pse_pkg::CODE_LF);
  assign need        = (min_len_r == '0) ? CFG_W'(1) : min_len_r;
  assign rd_last     = (CNT_W'(rd_idx_r) + CNT_W'(1)) == rep_len_r;
  assign issue       = (st_r == ST_REPLAY) && rd_ok;

  // writes only while collecting, reads only while replaying
  assign wr_en   = accept && printable;
  assign wr_addr = cnt_r[ADDR_W-1:0];
  assign wr_data = in_ch.data_byte;
  assign rd_addr = rd_idx_r;

  assign rd_tag.issue  = issue;
  assign rd_tag.last   = rd_last;
  assign rd_tag.offset = start_r;

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    rep_len_nxt = rep_len_r;
    rd_idx_nxt  = rd_idx_r;
    start_nxt   = start_r;
    pos_nxt     = pos_r;
    unique case (st_r)
      ST_COLLECT: begin
        if (accept) begin
          pos_nxt = pos_r + OFF_W'(1);
          if (printable) begin
            if (cnt_r == '0) begin
              start_nxt = pos_r;
            end
            if (cnt_r == CNT_W'(RUN_DEPTH - 1)) begin
              rep_len_nxt = CNT_W'(RUN_DEPTH);
              rd_idx_nxt  = '0;
              cnt_nxt     = '0;
              st_nxt      = ST_REPLAY;
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            if (term && (CFG_W'(cnt_r) >= need)) begin
              rep_len_nxt = cnt_r;
              rd_idx_nxt  = '0;
              st_nxt      = ST_REPLAY;
            end
            cnt_nxt = '0;
          end
        end
      end
      ST_REPLAY: begin
        if (issue) begin
          if (rd_last) begin
            st_nxt = ST_COLLECT;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          end
        end
      end
      default: begin
        st_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_COLLECT;
      cnt_r     <= '0;
      rep_len_r <= '0;
      rd_idx_r  <= '0;
      start_r   <= '0;
      pos_r     <= '0;
      min_len_r <= pse_pkg::MIN_LEN_RST;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      rep_len_r <= rep_len_nxt;
      rd_idx_r  <= rd_idx_nxt;
      start_r   <= start_nxt;
      pos_r     <= pos_nxt;
      if (cfg_we) begin
        min_len_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pse_replay_out.sv
`default_nettype none

module pse_replay_out (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pse_pkg::pse_rd_tag_t        rd_tag,
  input  wire logic [pse_pkg::DATA_W-1:0]  rd_data,
  output logic                             rd_ok,
  pse_out_if.source                        out_ch
);

  localparam int CHAR_W = pse_pkg::CHAR_W;
  localparam int OFF_W  = pse_pkg::OFF_W;

  // stage 1: memory read data register plus its tag
  logic              s1_valid_r, s1_valid_nxt;
  logic [OFF_W-1:0]  s1_off_r;
  logic              s1_last_r;

  // stage 2: output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic [OFF_W-1:0]  out_off_r;
  logic              out_last_r;

  logic              out_free;
  logic              s1_adv;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign rd_ok    = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_tag.issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_tag.issue) begin
      s1_off_r  <= rd_tag.offset;
      s1_last_r <= rd_tag.last;
    end
    if (s1_adv) begin
      out_char_r <= rd_data[CHAR_W-1:0];
      out_off_r  <= s1_off_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.text_char  = out_char_r;
  assign out_ch.run_offset = out_off_r;
  assign out_ch.run_last   = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/printable_string_extractor.sv
// channel   dir  payload                                   width
// in_ch     in   data_byte                                 8
// out_ch    out  text_char, run_offset, run_last           7, 32, 1
// cfg       in   cfg_we, cfg_data (min_length)             1, 7
//
// Collect: one byte per cycle, printable bytes written into the run buffer.
// Replay: a reported run is read out one char at a time on the buffer's single
//   read port, with in_ch.ready low meanwhile; output stalls hold it.
// Two-deep read/output pipeline; input resumes once the last read is issued.
// Reset is synchronous; the run buffer needs no clearing pass.
`default_nettype none

`include "printable_string_extractor_macros.svh"

module printable_string_extractor #(
  parameter int RUN_DEPTH = pse_pkg::RUN_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  pse_in_if.sink                         in_ch,
  pse_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [pse_pkg::CFG_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(RUN_DEPTH);

  pse_pkg::pse_rd_tag_t         rd_tag;
  logic                         rd_ok;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [pse_pkg::DATA_W-1:0]   wr_data;
  logic [ADDR_W-1:0]            rd_addr;
  logic [pse_pkg::DATA_W-1:0]   rd_data;

  pse_scan #(.RUN_DEPTH(RUN_DEPTH)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rd_ok    (rd_ok),
    .rd_tag   (rd_tag),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr)
  );

  pse_run_mem #(.RUN_DEPTH(RUN_DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_tag.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pse_replay_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_tag  (rd_tag),
    .rd_data (rd_data),
    .rd_ok   (rd_ok),
    .out_ch  (out_ch)
  );

  `PSE_ASSERT_IMPLY(a_no_rw_overlap, clk, rst_n, wr_en, !rd_tag.issue)
  `PSE_ASSERT_IMPLY(a_issue_has_room, clk, rst_n, rd_tag.issue, rd_ok)
  `PSE_ASSERT_NEXT(a_last_read_resumes, clk, rst_n, rd_tag.issue && rd_tag.last, in_ch.ready)

endmodule

`default_nettype wire
